/* rtl/core/circulant_route_direction_defines.svh */
// ---------------------------------------------------------------------------
// Assertion macros for the circulant route direction block
// Concurrent checks clocked on clk_i and disabled while rst_ni is low.
// ---------------------------------------------------------------------------
`ifndef CIRCULANT_ROUTE_DIRECTION_DEFINES_SVH
`define CIRCULANT_ROUTE_DIRECTION_DEFINES_SVH

`ifndef SYNTHESIS
// General property check.
`define CRD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// Condition that must never be seen.
`define CRD_ASSERT_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) else $error(msg);
`else
`define CRD_ASSERT(lbl, prop, msg)
`define CRD_ASSERT_NEVER(lbl, expr, msg)
`endif

`endif

/* rtl/core/crd_pkg.sv */
// ---------------------------------------------------------------------------
// crd_pkg
// Shared constants, types and helpers of the circulant route direction block.
// ---------------------------------------------------------------------------
package crd_pkg;

  localparam int unsigned COORD_BITS = 8;
  localparam int unsigned ENTRY_BITS = 2 * COORD_BITS;
  localparam int unsigned NODE_BITS  = 10;
  localparam int unsigned MAX_NODES  = 1024;
  localparam int unsigned NODE_AW    = $clog2(MAX_NODES);
  localparam int unsigned NUM_ZREGS  = 4;
  localparam int unsigned ZIDX_W     = $clog2(NUM_ZREGS);
  localparam int unsigned MAX_ZEROS  = 4;
  localparam int unsigned MAX_ROUNDS = 10;
  localparam int unsigned HOP_BITS   = 10;
  localparam int unsigned CAND_BITS  = 12;
  localparam int unsigned BOUND_BITS = 8;
  localparam int unsigned ZCNT_W     = 3;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned IN_DATA_W  = 40;
  localparam int unsigned OUT_DATA_W = 24;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BOUND  = 3'd0,
    CFG_ZCOUNT = 3'd1,
    CFG_ZVEC_A = 3'd2,
    CFG_ZVEC_B = 3'd3,
    CFG_ZVEC_C = 3'd4,
    CFG_ZVEC_D = 3'd5
  } cfg_idx_e;

  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_ROUTE = 1'b1
  } op_e;

  typedef enum logic [2:0] {
    DIR_LOCAL = 3'd0,
    DIR_NORTH = 3'd1,
    DIR_SOUTH = 3'd2,
    DIR_EAST  = 3'd3,
    DIR_WEST  = 3'd4
  } dir_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD_W,
    ST_LOAD,
    ST_GREEDY,
    ST_PAIR,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] x;
    logic signed [COORD_BITS-1:0] y;
  } zvec_t;

  // Control of one candidate evaluation.
  typedef struct packed {
    logic valid;
    logic sub_a;
    logic use_b;
    logic sub_b;
  } cand_ctl_t;

  typedef struct packed {
    logic                       take;
    logic                       hit;
    logic signed [HOP_BITS-1:0] x;
    logic signed [HOP_BITS-1:0] y;
    logic [HOP_BITS-1:0]        len;
  } cand_res_t;

  // Manhattan length of a vector.
  function automatic logic [CAND_BITS-1:0] len_f(input logic signed [CAND_BITS-1:0] x,
                                                 input logic signed [CAND_BITS-1:0] y);
    logic [CAND_BITS-1:0] ax;
    logic [CAND_BITS-1:0] ay;
    ax = x[CAND_BITS-1] ? CAND_BITS'(-x) : CAND_BITS'(x);
    ay = y[CAND_BITS-1] ? CAND_BITS'(-y) : CAND_BITS'(y);
    return ax + ay;
  endfunction

endpackage

/* rtl/core/crd_ram.sv */
// ---------------------------------------------------------------------------
// crd_ram
// Generic single-write, single-read RAM with a registered read port.
// ---------------------------------------------------------------------------
module crd_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 1024,
  localparam int unsigned AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/core/crd_cand.sv */
// ---------------------------------------------------------------------------
// crd_cand
// Candidate evaluator: adds one or two signed zero vectors to the current
// route vector and tests the strict-shrink and bound conditions.
// ---------------------------------------------------------------------------
module crd_cand (
  input  logic signed [crd_pkg::HOP_BITS-1:0]   bx_i,
  input  logic signed [crd_pkg::HOP_BITS-1:0]   by_i,
  input  logic [crd_pkg::HOP_BITS-1:0]          best_i,
  input  logic [crd_pkg::BOUND_BITS-1:0]        bound_i,
  input  crd_pkg::zvec_t                        za_i,
  input  crd_pkg::zvec_t                        zb_i,
  input  crd_pkg::cand_ctl_t                    ctl_i,
  output crd_pkg::cand_res_t                    res_o
);

  localparam int unsigned Cb   = crd_pkg::CAND_BITS;
  localparam int unsigned ZExt = crd_pkg::CAND_BITS - crd_pkg::COORD_BITS;
  localparam int unsigned BExt = crd_pkg::CAND_BITS - crd_pkg::HOP_BITS;
  localparam int unsigned DExt = crd_pkg::CAND_BITS - crd_pkg::BOUND_BITS;

  logic signed [Cb-1:0] ax, ay, tx, ty, sx, sy;
  logic [Cb-1:0]        len;

  always_comb begin
    ax = {{ZExt{za_i.x[crd_pkg::COORD_BITS-1]}}, za_i.x};
    ay = {{ZExt{za_i.y[crd_pkg::COORD_BITS-1]}}, za_i.y};
    if (ctl_i.sub_a) begin
      ax = -ax;
      ay = -ay;
    end
    tx = '0;
    ty = '0;
    if (ctl_i.use_b) begin
      tx = {{ZExt{zb_i.x[crd_pkg::COORD_BITS-1]}}, zb_i.x};
      ty = {{ZExt{zb_i.y[crd_pkg::COORD_BITS-1]}}, zb_i.y};
      if (ctl_i.sub_b) begin
        tx = -tx;
        ty = -ty;
      end
    end
    sx  = {{BExt{bx_i[crd_pkg::HOP_BITS-1]}}, bx_i} + ax + tx;
    sy  = {{BExt{by_i[crd_pkg::HOP_BITS-1]}}, by_i} + ay + ty;
    len = crd_pkg::len_f(sx, sy);

    res_o.take = ctl_i.valid && (len < {{BExt{1'b0}}, best_i});
    res_o.hit  = (len <= {{DExt{1'b0}}, bound_i});
    // Taken candidates are shorter than the current vector, so they fit.
    res_o.x    = sx[crd_pkg::HOP_BITS-1:0];
    res_o.y    = sy[crd_pkg::HOP_BITS-1:0];
    res_o.len  = len[crd_pkg::HOP_BITS-1:0];
  end

endmodule

/* rtl/core/circulant_route_direction.sv */
// ---------------------------------------------------------------------------
// circulant_route_direction
// First-hop route computation for a circulant network-on-chip in virtual
// 2-D coordinates.
// ---------------------------------------------------------------------------
// A coordinate memory (1024 x 16 bit, registered read port) holds the
// virtual (x, y) of each node and is loaded by write requests (tuser = 0);
// a write gives no result. A route request (tuser = 1) reads the current
// and the destination node in turn, forms the difference vector and, while
// its Manhattan length exceeds distance_bound, reduces it with the
// configured zero vectors: greedy rounds that try +z and -z of all four
// zero slots, then signed pairs of distinct slots. One candidate is
// evaluated per cycle by a single evaluator, and the two table reads share
// the one read port. A finished route waits until the output register is
// free; the result then sits in that register, so the next request is
// taken while it waits. Table entries come out of reset undefined and must
// be written before a route reads them; there is no clearing pass.
// Configuration must be written only while idle; the block itself does not
// enforce this.
// ---------------------------------------------------------------------------
`include "circulant_route_direction_defines.svh"

module circulant_route_direction #(
  parameter int unsigned MaxZeros  = crd_pkg::MAX_ZEROS,
  parameter int unsigned MaxRounds = crd_pkg::MAX_ROUNDS
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // Configuration write port
  input  logic                              cfg_we_i,
  input  logic [crd_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [crd_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  // Request stream
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // tdata: node_id[9:0], dest_id[19:10], coord_x[27:20], coord_y[35:28], zero pad
  input  logic [crd_pkg::IN_DATA_W-1:0]     s_axis_tdata,
  // tuser: operation[0]
  input  logic                              s_axis_tuser,
  // Result stream
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // tdata: direction[2:0], hop_x[12:3], hop_y[22:13], zero pad
  output logic [crd_pkg::OUT_DATA_W-1:0]    m_axis_tdata
);

  localparam int unsigned Cw    = crd_pkg::COORD_BITS;
  localparam int unsigned Hw    = crd_pkg::HOP_BITS;
  localparam int unsigned Zw    = crd_pkg::ZIDX_W;
  localparam int unsigned Cb    = crd_pkg::CAND_BITS;
  localparam int unsigned NodeW = crd_pkg::NODE_BITS;
  localparam int unsigned RndW  = $clog2(MaxRounds + 1);
  localparam logic [crd_pkg::ZCNT_W-1:0] ZLim =
    crd_pkg::ZCNT_W'((MaxZeros < crd_pkg::NUM_ZREGS) ? MaxZeros : crd_pkg::NUM_ZREGS);
  localparam logic [Zw-1:0] LastIdx = Zw'(crd_pkg::NUM_ZREGS - 1);

  // ---------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------
  logic [crd_pkg::BOUND_BITS-1:0] distance_bound_q;
  logic [crd_pkg::ZCNT_W-1:0]     zero_count_q;
  logic [crd_pkg::ENTRY_BITS-1:0] zvec_q [crd_pkg::NUM_ZREGS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      distance_bound_q <= crd_pkg::BOUND_BITS'(1);
      zero_count_q     <= '0;
      for (int k = 0; k < crd_pkg::NUM_ZREGS; k++) begin
        zvec_q[k] <= '0;
      end
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        crd_pkg::CFG_BOUND:  distance_bound_q <= cfg_data_i[crd_pkg::BOUND_BITS-1:0];
        crd_pkg::CFG_ZCOUNT: zero_count_q     <= cfg_data_i[crd_pkg::ZCNT_W-1:0];
        crd_pkg::CFG_ZVEC_A: zvec_q[0]        <= cfg_data_i;
        crd_pkg::CFG_ZVEC_B: zvec_q[1]        <= cfg_data_i;
        crd_pkg::CFG_ZVEC_C: zvec_q[2]        <= cfg_data_i;
        crd_pkg::CFG_ZVEC_D: zvec_q[3]        <= cfg_data_i;
        default: ;  // drop writes to unknown indexes
      endcase
    end
  end

  // Usable zero slots: below the clamped count and not the null vector.
  // Skipping a null slot in the pair search keeps it out of every pair.
  logic [crd_pkg::ZCNT_W-1:0] zlim;
  logic [crd_pkg::NUM_ZREGS-1:0] zok;

  assign zlim = (zero_count_q > ZLim) ? ZLim : zero_count_q;

  for (genvar k = 0; k < crd_pkg::NUM_ZREGS; k++) begin : g_zok
    assign zok[k] = (crd_pkg::ZCNT_W'(k) < zlim) && (zvec_q[k] != '0);
  end

  // ---------------------------------------------------------------------
  // Request fields
  // ---------------------------------------------------------------------
  logic [NodeW-1:0] in_node, in_dest;
  logic [Cw-1:0]    in_cx, in_cy;

  assign in_node = s_axis_tdata[NodeW-1:0];
  assign in_dest = s_axis_tdata[2*NodeW-1:NodeW];
  assign in_cx   = s_axis_tdata[2*NodeW+Cw-1:2*NodeW];
  assign in_cy   = s_axis_tdata[2*NodeW+2*Cw-1:2*NodeW+Cw];

  // ---------------------------------------------------------------------
  // Coordinate memory
  // ---------------------------------------------------------------------
  logic                            ram_we, ram_re;
  logic [crd_pkg::NODE_AW-1:0]     ram_raddr;
  logic [crd_pkg::ENTRY_BITS-1:0]  ram_rdata;

  crd_ram #(
    .Width (crd_pkg::ENTRY_BITS),
    .Depth (crd_pkg::MAX_NODES)
  ) u_coord_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (in_node[crd_pkg::NODE_AW-1:0]),
    .wdata_i ({in_cx, in_cy}),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // ---------------------------------------------------------------------
  // Sequencer and vector registers
  // ---------------------------------------------------------------------
  crd_pkg::state_e state_q, state_d;
  logic [NodeW-1:0]        dst_q, dst_d;
  logic [Cw-1:0]           ux_q, ux_d, uy_q, uy_d;
  logic signed [Hw-1:0]    bx_q, bx_d, by_q, by_d;
  logic [Hw-1:0]           best_q, best_d;
  logic [Zw-1:0]           idx_a_q, idx_a_d, idx_b_q, idx_b_d;
  logic [1:0]              ps_q, ps_d;
  logic [RndW-1:0]         rnd_q, rnd_d;
  logic                    imp_q, imp_d;
  logic                    out_valid_q, out_valid_d;
  crd_pkg::dir_e           out_dir_q, out_dir_d;
  logic signed [Hw-1:0]    out_x_q, out_x_d, out_y_q, out_y_d;

  crd_pkg::cand_ctl_t      cand_ctl;
  crd_pkg::cand_res_t      cand_res;
  logic signed [Hw-1:0]    diff_x, diff_y;
  logic [Cb-1:0]           init_len;
  logic                    imp_next;
  crd_pkg::dir_e           dir;

  // Destination minus current; memory data is the destination entry here.
  assign diff_x = Hw'($signed(ram_rdata[2*Cw-1:Cw])) - Hw'($signed(ux_q));
  assign diff_y = Hw'($signed(ram_rdata[Cw-1:0]))    - Hw'($signed(uy_q));
  assign init_len = crd_pkg::len_f(Cb'(diff_x), Cb'(diff_y));

  crd_cand u_cand (
    .bx_i    (bx_q),
    .by_i    (by_q),
    .best_i  (best_q),
    .bound_i (distance_bound_q),
    .za_i    (crd_pkg::zvec_t'(zvec_q[idx_a_q])),
    .zb_i    (crd_pkg::zvec_t'(zvec_q[idx_b_q])),
    .ctl_i   (cand_ctl),
    .res_o   (cand_res)
  );

  // First hop: x decides before y.
  always_comb begin
    if (!bx_q[Hw-1] && (bx_q != '0)) begin
      dir = crd_pkg::DIR_SOUTH;
    end else if (bx_q[Hw-1]) begin
      dir = crd_pkg::DIR_NORTH;
    end else if (!by_q[Hw-1] && (by_q != '0)) begin
      dir = crd_pkg::DIR_EAST;
    end else if (by_q[Hw-1]) begin
      dir = crd_pkg::DIR_WEST;
    end else begin
      dir = crd_pkg::DIR_LOCAL;
    end
  end

  always_comb begin
    state_d     = state_q;
    dst_d       = dst_q;
    ux_d        = ux_q;
    uy_d        = uy_q;
    bx_d        = bx_q;
    by_d        = by_q;
    best_d      = best_q;
    idx_a_d     = idx_a_q;
    idx_b_d     = idx_b_q;
    ps_d        = ps_q;
    rnd_d       = rnd_q;
    imp_d       = imp_q;
    out_valid_d = out_valid_q & ~m_axis_tready;
    out_dir_d   = out_dir_q;
    out_x_d     = out_x_q;
    out_y_d     = out_y_q;
    ram_we      = 1'b0;
    ram_re      = 1'b0;
    ram_raddr   = in_node[crd_pkg::NODE_AW-1:0];
    cand_ctl    = '0;
    imp_next    = imp_q | cand_res.take;

    s_axis_tready = (state_q == crd_pkg::ST_IDLE);

    case (state_q)
      crd_pkg::ST_IDLE: begin
        if (s_axis_tvalid) begin
          if (s_axis_tuser == crd_pkg::OP_WRITE) begin
            ram_we = 1'b1;
          end else begin
            // Read the current node now, the destination next cycle.
            ram_re = 1'b1;
            dst_d  = in_dest;
            if (in_node == in_dest) begin
              bx_d    = '0;
              by_d    = '0;
              state_d = crd_pkg::ST_DONE;
            end else begin
              state_d = crd_pkg::ST_RD_W;
            end
          end
        end
      end

      crd_pkg::ST_RD_W: begin
        ram_re    = 1'b1;
        ram_raddr = dst_q[crd_pkg::NODE_AW-1:0];
        ux_d      = ram_rdata[2*Cw-1:Cw];
        uy_d      = ram_rdata[Cw-1:0];
        state_d   = crd_pkg::ST_LOAD;
      end

      crd_pkg::ST_LOAD: begin
        bx_d    = diff_x;
        by_d    = diff_y;
        best_d  = init_len[Hw-1:0];
        idx_a_d = '0;
        ps_d    = '0;
        rnd_d   = '0;
        imp_d   = 1'b0;
        if (init_len <= Cb'(distance_bound_q)) begin
          state_d = crd_pkg::ST_DONE;
        end else begin
          state_d = crd_pkg::ST_GREEDY;
        end
      end

      crd_pkg::ST_GREEDY: begin
        // ps_q[0]: 0 adds the slot, 1 subtracts it.
        cand_ctl.valid = zok[idx_a_q];
        cand_ctl.sub_a = ps_q[0];
        if (cand_res.take) begin
          bx_d   = cand_res.x;
          by_d   = cand_res.y;
          best_d = cand_res.len;
        end
        if (cand_res.take && cand_res.hit) begin
          state_d = crd_pkg::ST_DONE;
        end else if (!ps_q[0]) begin
          ps_d  = 2'b01;
          imp_d = imp_next;
        end else begin
          ps_d = '0;
          if (idx_a_q == LastIdx) begin
            // End of round: repeat while it improved and rounds remain.
            if (imp_next && ((rnd_q + 1'b1) < RndW'(MaxRounds))) begin
              rnd_d   = rnd_q + 1'b1;
              idx_a_d = '0;
              imp_d   = 1'b0;
            end else begin
              idx_a_d = '0;
              idx_b_d = Zw'(1);
              state_d = crd_pkg::ST_PAIR;
            end
          end else begin
            idx_a_d = idx_a_q + 1'b1;
            imp_d   = imp_next;
          end
        end
      end

      crd_pkg::ST_PAIR: begin
        // Sign order (-,-), (-,+), (+,-), (+,+).
        cand_ctl.valid = zok[idx_a_q] && zok[idx_b_q];
        cand_ctl.sub_a = ~ps_q[1];
        cand_ctl.use_b = 1'b1;
        cand_ctl.sub_b = ~ps_q[0];
        if (cand_res.take) begin
          bx_d   = cand_res.x;
          by_d   = cand_res.y;
          best_d = cand_res.len;
        end
        if (cand_res.take && cand_res.hit) begin
          state_d = crd_pkg::ST_DONE;
        end else if (ps_q == 2'b11) begin
          ps_d = '0;
          if (idx_b_q == LastIdx) begin
            if (idx_a_q == LastIdx - 1'b1) begin
              state_d = crd_pkg::ST_DONE;
            end else begin
              idx_a_d = idx_a_q + 1'b1;
              idx_b_d = idx_a_q + Zw'(2);
            end
          end else begin
            idx_b_d = idx_b_q + 1'b1;
          end
        end else begin
          ps_d = ps_q + 1'b1;
        end
      end

      crd_pkg::ST_DONE: begin
        // Hold until the output register is free, then hand the result over.
        if (!out_valid_q || m_axis_tready) begin
          out_valid_d = 1'b1;
          out_dir_d   = dir;
          out_x_d     = bx_q;
          out_y_d     = by_q;
          state_d     = crd_pkg::ST_IDLE;
        end
      end

      default: begin
        state_d = crd_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= crd_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
      idx_a_q     <= '0;
      idx_b_q     <= '0;
      ps_q        <= '0;
      rnd_q       <= '0;
      imp_q       <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      idx_a_q     <= idx_a_d;
      idx_b_q     <= idx_b_d;
      ps_q        <= ps_d;
      rnd_q       <= rnd_d;
      imp_q       <= imp_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    dst_q     <= dst_d;
    ux_q      <= ux_d;
    uy_q      <= uy_d;
    bx_q      <= bx_d;
    by_q      <= by_d;
    best_q    <= best_d;
    out_dir_q <= out_dir_d;
    out_x_q   <= out_x_d;
    out_y_q   <= out_y_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {1'b0, out_y_q, out_x_q, out_dir_q};

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  `CRD_ASSERT(a_reduce_above_bound,
    ((state_q == crd_pkg::ST_GREEDY) || (state_q == crd_pkg::ST_PAIR))
      |-> (best_q > Hw'(distance_bound_q)),
    "reduction running with length already within bound")
  `CRD_ASSERT(a_len_never_grows,
    ((state_q == crd_pkg::ST_GREEDY) || (state_q == crd_pkg::ST_PAIR))
      |=> (best_q <= $past(best_q)),
    "route vector length grew during reduction")
  `CRD_ASSERT(a_local_iff_zero,
    m_axis_tvalid
      |-> ((out_dir_q == crd_pkg::DIR_LOCAL) == ((out_x_q == '0) && (out_y_q == '0))),
    "direction local does not match a null hop vector")
  `CRD_ASSERT(a_done_hands_over,
    ((state_q == crd_pkg::ST_DONE) && (!out_valid_q || m_axis_tready))
      |=> (m_axis_tvalid && (state_q == crd_pkg::ST_IDLE)),
    "finished result not moved to the output register")

endmodule
